/* hw/rtl/ubid_pkg.sv */
// ----------------------------------------------------------------------------
// ubid_pkg
// Types and constants shared by the boot image download host core.
// ----------------------------------------------------------------------------
package ubid_pkg;

    localparam int unsigned TICK_W = 20;

    localparam logic [7:0]        BYTE_STX = 8'h02;
    localparam logic [7:0]        BYTE_SOH = 8'h01;
    localparam logic [7:0]        BYTE_ACK = 8'h06;
    localparam logic [7:0]        BYTE_NAK = 8'h15;
    localparam logic [TICK_W-1:0] TICK_MAX = 20'hFFFFF;

    localparam logic [TICK_W-1:0] START_TIMEOUT_RST = 20'd20000;
    localparam logic [TICK_W-1:0] REPLY_TIMEOUT_RST = 20'd2000;
    localparam logic [TICK_W-1:0] IDLE_TIMEOUT_RST  = 20'd300000;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_TARGET = 2'd1,
        CMD_HOST   = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_START_TIMEOUT = 2'd0,
        CFG_REPLY_TIMEOUT = 2'd1,
        CFG_IDLE_TIMEOUT  = 2'd2
    } cfg_index_t;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_WAIT_STX = 5'b00010,
        PH_WAIT_ACK = 5'b00100,
        PH_DATA     = 5'b01000,
        PH_WAIT_SUM = 5'b10000
    } phase_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] image_size;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [TICK_W-1:0] start_timeout;
        logic [TICK_W-1:0] reply_timeout;
        logic [TICK_W-1:0] idle_timeout;
    } cfg_t;

    typedef struct packed {
        phase_t            phase;
        logic [15:0]       bytes_left;
        logic [7:0]        checksum;
        logic [TICK_W-1:0] elapsed;
    } dl_state_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       finished;
        logic       success;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0]        count;
        result_t [2:0]     res;
    } result_set_t;

endpackage

/* hw/rtl/ubid_step.sv */
// ----------------------------------------------------------------------------
// ubid_step
// Next-state and result logic for one word of the download protocol.
// ----------------------------------------------------------------------------
module ubid_step
    import ubid_pkg::*;
(
    input  item_t       item,
    input  cfg_t        cfg,
    input  dl_state_t   state,
    output dl_state_t   state_next,
    output result_set_t results
);

    logic [TICK_W-1:0] elapsed_inc;
    logic [TICK_W-1:0] limit;
    logic              nak;
    logic [15:0]       bytes_dec;

    assign elapsed_inc = (state.elapsed == TICK_MAX) ? state.elapsed
                                                     : state.elapsed + 20'd1;
    assign bytes_dec   = state.bytes_left - 16'd1;

    always_comb
    begin
        unique case (state.phase)
            PH_WAIT_STX:
            begin
                limit = cfg.start_timeout;
                nak   = 1'b0;
            end
            PH_WAIT_ACK:
            begin
                limit = cfg.reply_timeout;
                nak   = 1'b0;
            end
            PH_DATA:
            begin
                limit = cfg.idle_timeout;
                nak   = 1'b1;
            end
            default:
            begin
                limit = cfg.reply_timeout;
                nak   = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state;
        results.count = 2'd0;
        results.res   = '0;
        case (item.cmd)
            CMD_START:
            begin
                if (state.phase == PH_IDLE)
                begin
                    state_next.bytes_left = item.image_size;
                    state_next.checksum   = 8'h00;
                    state_next.phase      = PH_WAIT_STX;
                    state_next.elapsed    = '0;
                end
            end
            CMD_TARGET:
            begin
                if (state.phase == PH_WAIT_STX && item.data_byte == BYTE_STX)
                begin
                    results.count  = 2'd3;
                    results.res[0] = '{1'b1, BYTE_SOH, 1'b0, 1'b0, 1'b0};
                    results.res[1] = '{1'b1, state.bytes_left[7:0], 1'b0, 1'b0, 1'b0};
                    results.res[2] = '{1'b1, state.bytes_left[15:8], 1'b0, 1'b0, 1'b1};
                    state_next.phase   = PH_WAIT_ACK;
                    state_next.elapsed = '0;
                end
                else if (state.phase == PH_WAIT_ACK && item.data_byte == BYTE_ACK)
                begin
                    state_next.phase   = (state.bytes_left == 16'd0) ? PH_WAIT_SUM
                                                                    : PH_DATA;
                    state_next.elapsed = '0;
                end
                else if (state.phase == PH_WAIT_SUM && item.data_byte == state.checksum)
                begin
                    results.count  = 2'd1;
                    results.res[0] = '{1'b1, BYTE_ACK, 1'b1, 1'b1, 1'b1};
                    state_next.phase   = PH_IDLE;
                    state_next.elapsed = '0;
                end
            end
            CMD_HOST:
            begin
                if (state.phase == PH_DATA)
                begin
                    results.count  = 2'd1;
                    results.res[0] = '{1'b1, item.data_byte, 1'b0, 1'b0, 1'b1};
                    state_next.checksum   = state.checksum ^ item.data_byte;
                    state_next.bytes_left = bytes_dec;
                    state_next.phase      = (bytes_dec == 16'd0) ? PH_WAIT_SUM : PH_DATA;
                    state_next.elapsed    = '0;
                end
            end
            default:
            begin
                if (state.phase != PH_IDLE)
                begin
                    state_next.elapsed = elapsed_inc;
                    if (elapsed_inc > limit)
                    begin
                        // silent failure in the handshake waits, nak otherwise
                        results.count  = 2'd1;
                        results.res[0] = '{nak, nak ? BYTE_NAK : 8'h00, 1'b1, 1'b0, 1'b1};
                        state_next.phase   = PH_IDLE;
                        state_next.elapsed = '0;
                    end
                end
            end
        endcase
    end

endmodule

/* hw/rtl/ubid_outbuf.sv */
// ----------------------------------------------------------------------------
// ubid_outbuf
// Three-entry result buffer; loaded as a set, drained one word at a time.
// ----------------------------------------------------------------------------
module ubid_outbuf
    import ubid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  result_set_t load_set,
    output logic        can_load,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     head
);

    result_t [2:0] entry_reg;
    logic [1:0]    count_reg;
    logic          pop;

    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    // a new set may land once the last waiting word leaves
    assign can_load  = (count_reg == 2'd0) || (count_reg == 2'd1 && out_ready);
    assign head      = entry_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (load)
        begin
            count_reg <= load_set.count;
        end
        else if (pop)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= load_set.res;
        end
        else if (pop)
        begin
            entry_reg[0] <= entry_reg[1];
            entry_reg[1] <= entry_reg[2];
        end
    end

endmodule

/* hw/rtl/uart_boot_image_download_host_core.sv */
// Flow: a word is registered at acceptance and evaluated from that register
// once the result buffer can take its results, which are offered from there.
// Throughput: one word per cycle while out_ready is high and each word gives
// at most one result; the three STX results leave the buffer one at a time.
// Reset: asynchronous, clears phase, counters and buffer, timeouts to defaults.
// ----------------------------------------------------------------------------
// uart_boot_image_download_host_core
// Host side of a UART boot download with XOR checksum and phase timeouts.
// ----------------------------------------------------------------------------
module uart_boot_image_download_host_core
    import ubid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [15:0] image_size,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        finished,
    output logic        success,
    output logic        last
);

    cfg_t        cfg_reg;
    item_t       item_reg;
    logic        item_valid_reg;
    dl_state_t   state_reg;
    dl_state_t   state_next;
    result_set_t results;
    result_t     head;
    logic        buf_can_load;
    logic        step_fire;

    assign step_fire = item_valid_reg && buf_can_load;
    assign in_ready  = !item_valid_reg || step_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_timeout <= START_TIMEOUT_RST;
            cfg_reg.reply_timeout <= REPLY_TIMEOUT_RST;
            cfg_reg.idle_timeout  <= IDLE_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_START_TIMEOUT: cfg_reg.start_timeout <= cfg_data;
                CFG_REPLY_TIMEOUT: cfg_reg.reply_timeout <= cfg_data;
                CFG_IDLE_TIMEOUT:  cfg_reg.idle_timeout  <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.cmd        <= cmd_t'(cmd);
            item_reg.image_size <= image_size;
            item_reg.data_byte  <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= PH_IDLE;
            state_reg.bytes_left <= 16'd0;
            state_reg.checksum   <= 8'h00;
            state_reg.elapsed    <= '0;
        end
        else if (step_fire)
        begin
            state_reg <= state_next;
        end
    end

    ubid_step u_step (
        .item       (item_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .results    (results)
    );

    ubid_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step_fire),
        .load_set  (results),
        .can_load  (buf_can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign tx_valid = head.tx_valid;
    assign tx_byte  = head.tx_byte;
    assign finished = head.finished;
    assign success  = head.success;
    assign last     = head.last;

endmodule

/* hw/rtl/ubid_checker.sv */
// ----------------------------------------------------------------------------
// ubid_checker
// Port-level checks on the result channel of the download host core.
// ----------------------------------------------------------------------------
module ubid_checker
    import ubid_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       tx_valid,
    input logic [7:0] tx_byte,
    input logic       finished,
    input logic       success,
    input logic       last
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(last))
        else $error("result word changed while stalled");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> last)
        else $error("end of download not on last word");

    a_idle_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tx_valid |-> tx_byte == 8'h00)
        else $error("byte set without tx_valid");

    a_success_ack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && success |-> finished && tx_valid && tx_byte == BYTE_ACK)
        else $error("success without final ack");

    a_fail_nak: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished && !success && tx_valid |-> tx_byte == BYTE_NAK)
        else $error("failed download sent a byte other than nak");

endmodule

bind uart_boot_image_download_host_core ubid_checker u_checker (.*);

/* test/uart_boot_image_download_host_core_tb.sv */
// ----------------------------------------------------------------------------
// uart_boot_image_download_host_core_tb
// Feeds start, target-byte, host-byte and tick words into the download host
// core, predicts each outgoing result word and checks the results in order.
// ----------------------------------------------------------------------------
module uart_boot_image_download_host_core_tb;
    import ubid_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          PHASE_WORDS  = 75;
    localparam int          DIR_ROWS     = 26;
    localparam int          NO_EXCL      = 256;
    localparam result_t     NO_RES       = '0;

    typedef struct packed {
        logic        zero_first;
        cmd_t        c;
        logic [15:0] sz;
        logic [7:0]  b;
        logic        typed;
        logic [1:0]  n_typed;
        result_t     r;
    } dir_row_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [1:0]  cfg_index  = 2'b00;
    logic [19:0] cfg_data   = 20'h00000;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    cmd_t        cmd        = CMD_START;
    logic [15:0] image_size = 16'h0000;
    logic [7:0]  data_byte  = 8'h00;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        finished;
    logic        success;
    logic        last;

    // expectation carried alongside the word being offered
    logic        drv_typed     = 1'b0;
    logic [1:0]  drv_typed_n   = 2'd0;
    result_t     drv_typed_res = '0;

    dl_state_t   dl;
    cfg_t        lim;
    result_t     pred_res [0:2];
    int          pred_cnt;
    item_t       seen_item;
    result_t     want;
    int          res_idx;

    result_t     tx_expected_q [$];
    int          mismatch_count = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    int unsigned flush_len      = 2;
    int          phase_words    = 0;
    int          cycle_count    = 0;
    dir_row_t    dir_rows [0:DIR_ROWS-1];

    uart_boot_image_download_host_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .image_size (image_size),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .tx_valid   (tx_valid),
        .tx_byte    (tx_byte),
        .finished   (finished),
        .success    (success),
        .last       (last)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    function automatic result_t mk_res(input logic v, input logic [7:0] b, input logic fin,
                                       input logic ok, input logic lst);
        result_t r;
        r.tx_valid = v;
        r.tx_byte  = v ? b : 8'h00;
        r.finished = fin;
        r.success  = fin ? ok : 1'b0;
        r.last     = lst;
        return r;
    endfunction

    function automatic dir_row_t step_row(input logic zero_first, input cmd_t c,
                                          input logic [15:0] sz, input logic [7:0] b,
                                          input logic typed, input logic [1:0] n,
                                          input result_t r);
        dir_row_t row;
        row.zero_first = zero_first;
        row.c          = c;
        row.sz         = sz;
        row.b          = b;
        row.typed      = typed;
        row.n_typed    = n;
        row.r          = r;
        return row;
    endfunction

    function void enter_phase(input phase_t p);
        dl.phase   = p;
        dl.elapsed = '0;
    endfunction

    // next state of the download and the result words one word causes
    function void download_step(input item_t it);
        logic [TICK_W-1:0] limit;
        logic              nak;
        pred_cnt = 0;
        case (it.cmd)
            CMD_START:
                if (dl.phase == PH_IDLE)
                begin
                    dl.bytes_left = it.image_size;
                    dl.checksum   = '0;
                    enter_phase(PH_WAIT_STX);
                end
            CMD_TARGET:
                if (dl.phase == PH_WAIT_STX && it.data_byte == BYTE_STX)
                begin
                    pred_res[0] = mk_res(1'b1, BYTE_SOH, 1'b0, 1'b0, 1'b0);
                    pred_res[1] = mk_res(1'b1, dl.bytes_left[7:0], 1'b0, 1'b0, 1'b0);
                    pred_res[2] = mk_res(1'b1, dl.bytes_left[15:8], 1'b0, 1'b0, 1'b1);
                    pred_cnt    = 3;
                    enter_phase(PH_WAIT_ACK);
                end
                else if (dl.phase == PH_WAIT_ACK && it.data_byte == BYTE_ACK)
                begin
                    if (dl.bytes_left == 16'h0000)
                        enter_phase(PH_WAIT_SUM);
                    else
                        enter_phase(PH_DATA);
                end
                else if (dl.phase == PH_WAIT_SUM && it.data_byte == dl.checksum)
                begin
                    pred_res[0] = mk_res(1'b1, BYTE_ACK, 1'b1, 1'b1, 1'b1);
                    pred_cnt    = 1;
                    enter_phase(PH_IDLE);
                end
            CMD_HOST:
                if (dl.phase == PH_DATA)
                begin
                    pred_res[0]   = mk_res(1'b1, it.data_byte, 1'b0, 1'b0, 1'b1);
                    pred_cnt      = 1;
                    dl.checksum   = dl.checksum ^ it.data_byte;
                    dl.bytes_left = dl.bytes_left - 16'd1;
                    // every image byte restarts the idle count
                    if (dl.bytes_left == 16'h0000)
                        enter_phase(PH_WAIT_SUM);
                    else
                        enter_phase(PH_DATA);
                end
            default:
                if (dl.phase != PH_IDLE)
                begin
                    if (dl.elapsed != TICK_MAX)
                        dl.elapsed = dl.elapsed + 1'b1;
                    case (dl.phase)
                        PH_WAIT_STX: limit = lim.start_timeout;
                        PH_DATA:     limit = lim.idle_timeout;
                        default:     limit = lim.reply_timeout;
                    endcase
                    // header waits fail silently, data and checksum waits send nak
                    nak = (dl.phase == PH_DATA) || (dl.phase == PH_WAIT_SUM);
                    if (dl.elapsed > limit)
                    begin
                        pred_res[0] = mk_res(nak, BYTE_NAK, 1'b1, 1'b0, 1'b1);
                        pred_cnt    = 1;
                        enter_phase(PH_IDLE);
                    end
                end
        endcase
    endfunction

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned got_val);
        if (exp_val != got_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            lim.start_timeout = START_TIMEOUT_RST;
            lim.reply_timeout = REPLY_TIMEOUT_RST;
            lim.idle_timeout  = IDLE_TIMEOUT_RST;
            dl.phase          = PH_IDLE;
            dl.bytes_left     = '0;
            dl.checksum       = '0;
            dl.elapsed        = '0;
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    CFG_START_TIMEOUT: lim.start_timeout = cfg_data;
                    CFG_REPLY_TIMEOUT: lim.reply_timeout = cfg_data;
                    CFG_IDLE_TIMEOUT:  lim.idle_timeout  = cfg_data;
                    default: ;
                endcase
            if (out_valid && out_ready)
            begin
                if (tx_expected_q.size() == 0)
                begin
                    $error("result word with nothing expected: tx_byte 0x%0h", tx_byte);
                    mismatch_count++;
                end
                else
                begin
                    want = tx_expected_q.pop_front();
                    check_field("tx_valid", want.tx_valid, tx_valid);
                    check_field("tx_byte",  want.tx_byte,  tx_byte);
                    check_field("finished", want.finished, finished);
                    check_field("success",  want.success,  success);
                    check_field("last",     want.last,     last);
                end
            end
            if (in_valid && in_ready)
            begin
                seen_item.cmd        = cmd;
                seen_item.image_size = image_size;
                seen_item.data_byte  = data_byte;
                download_step(seen_item);
                if (drv_typed)
                begin
                    if (drv_typed_n != 2'd0)
                        tx_expected_q.push_back(drv_typed_res);
                end
                else
                    for (res_idx = 0; res_idx < pred_cnt; res_idx++)
                        tx_expected_q.push_back(pred_res[res_idx]);
            end
        end
    end

    task automatic send_word(input cmd_t c, input logic [15:0] sz, input logic [7:0] b,
                             input logic typed, input logic [1:0] n, input result_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        cmd           <= c;
        image_size    <= sz;
        data_byte     <= b;
        drv_typed     <= typed;
        drv_typed_n   <= n;
        drv_typed_res <= r;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic push_word(input cmd_t c, input logic [15:0] sz, input logic [7:0] b);
        send_word(c, sz, b, 1'b0, 2'd0, NO_RES);
    endtask

    // wait until every result is out and the core has settled
    task automatic await_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tx_expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeouts(input logic [19:0] t_start, input logic [19:0] t_reply,
                                  input logic [19:0] t_idle);
        await_quiet();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_START_TIMEOUT;
        cfg_data  <= t_start;
        @(posedge clk);
        cfg_index <= CFG_REPLY_TIMEOUT;
        cfg_data  <= t_reply;
        @(posedge clk);
        cfg_index <= CFG_IDLE_TIMEOUT;
        cfg_data  <= t_idle;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // enough ticks to time out whichever wait is open
    task automatic flush_ticks();
        repeat (flush_len) push_word(CMD_TICK, 16'($urandom), 8'($urandom));
    endtask

    // a word the current phase should ignore, apart from ticks that may time it out
    task automatic stray_word(input int excl, input bit host_ok);
        int b;
        do
            b = $urandom_range(0, 255);
        while (b == excl);
        case ($urandom_range(0, 4))
            0: push_word(CMD_TICK, 16'($urandom), 8'(b));
            1: push_word(CMD_START, 16'($urandom), 8'(b));
            2:
                if (host_ok)
                    push_word(CMD_HOST, 16'($urandom), 8'(b));
                else
                    push_word(CMD_TARGET, 16'($urandom), 8'(b));
            default: push_word(CMD_TARGET, 16'($urandom), 8'(b));
        endcase
    endtask

    // one download: start, stx, ack, image bytes, checksum; broken ones stop early
    task automatic run_download(input bit finite);
        int unsigned size;
        int unsigned cut;
        int unsigned cut_max;
        int unsigned s;
        logic [7:0]  sum;
        logic [7:0]  b;
        bit          broken;
        size    = (finite && $urandom_range(0, 11) == 0) ? $urandom_range(0, 65535)
                                                        : $urandom_range(0, 6);
        broken  = finite && (size > 6 || $urandom_range(0, 4) == 0);
        cut_max = (size + 3 < 12) ? size + 3 : 12;
        cut     = broken ? $urandom_range(1, cut_max) : size + 4;
        sum     = 8'h00;
        if ($urandom_range(0, 5) == 0)
            push_word(CMD_TARGET, 16'($urandom), 8'($urandom));
        for (s = 0; s < cut; s++)
        begin
            if (s > 0 && $urandom_range(0, 4) == 0)
            begin
                if (s == 1)
                    stray_word(BYTE_STX, 1'b1);
                else if (s == 2)
                    stray_word(BYTE_ACK, 1'b1);
                else if (s < size + 3)
                    stray_word(NO_EXCL, 1'b0);
                else
                    stray_word(sum, 1'b1);
            end
            if (s == 0)
                push_word(CMD_START, 16'(size), 8'($urandom));
            else if (s == 1)
                push_word(CMD_TARGET, 16'($urandom), BYTE_STX);
            else if (s == 2)
                push_word(CMD_TARGET, 16'($urandom), BYTE_ACK);
            else if (s < size + 3)
            begin
                b   = 8'($urandom);
                sum = sum ^ b;
                push_word(CMD_HOST, 16'($urandom), b);
            end
            else
                push_word(CMD_TARGET, 16'($urandom), sum);
            phase_words++;
        end
        if (broken)
        begin
            if (cut == size + 3)
            begin
                b = 8'($urandom_range(1, 255));
                push_word(CMD_TARGET, 16'($urandom), sum ^ b);
            end
            flush_ticks();
        end
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int          i;
        int          p;
        logic [19:0] ts;
        logic [19:0] tr;
        logic [19:0] ti;

        // reset timeouts first, then all limits at zero
        dir_rows[0]  = step_row(1'b0, CMD_TICK,   16'h0000, 8'h00,    1'b1, 2'd0, NO_RES);
        dir_rows[1]  = step_row(1'b0, CMD_HOST,   16'h0000, 8'hA5,    1'b1, 2'd0, NO_RES);
        dir_rows[2]  = step_row(1'b0, CMD_START,  16'h0002, 8'h00,    1'b1, 2'd0, NO_RES);
        dir_rows[3]  = step_row(1'b0, CMD_START,  16'hFFFF, 8'hFF,    1'b1, 2'd0, NO_RES);
        dir_rows[4]  = step_row(1'b0, CMD_TARGET, 16'h0000, BYTE_ACK, 1'b1, 2'd0, NO_RES);
        dir_rows[5]  = step_row(1'b0, CMD_TARGET, 16'h0000, BYTE_STX, 1'b0, 2'd0, NO_RES);
        dir_rows[6]  = step_row(1'b0, CMD_HOST,   16'h0000, 8'hFF,    1'b1, 2'd0, NO_RES);
        dir_rows[7]  = step_row(1'b0, CMD_TARGET, 16'h0000, BYTE_ACK, 1'b1, 2'd0, NO_RES);
        dir_rows[8]  = step_row(1'b0, CMD_TARGET, 16'h0000, BYTE_STX, 1'b1, 2'd0, NO_RES);
        dir_rows[9]  = step_row(1'b0, CMD_HOST,   16'h0000, 8'hFF,    1'b1, 2'd1,
                                mk_res(1'b1, 8'hFF, 1'b0, 1'b0, 1'b1));
        dir_rows[10] = step_row(1'b0, CMD_HOST,   16'h0000, 8'h00,    1'b1, 2'd1,
                                mk_res(1'b1, 8'h00, 1'b0, 1'b0, 1'b1));
        dir_rows[11] = step_row(1'b0, CMD_TARGET, 16'h0000, 8'h00,    1'b1, 2'd0, NO_RES);
        dir_rows[12] = step_row(1'b0, CMD_TARGET, 16'h0000, 8'hFF,    1'b1, 2'd1,
                                mk_res(1'b1, BYTE_ACK, 1'b1, 1'b1, 1'b1));
        dir_rows[13] = step_row(1'b1, CMD_START,  16'hFFFF, 8'h00,    1'b1, 2'd0, NO_RES);
        dir_rows[14] = step_row(1'b0, CMD_TICK,   16'h0000, 8'h00,    1'b1, 2'd1,
                                mk_res(1'b0, 8'h00, 1'b1, 1'b0, 1'b1));
        dir_rows[15] = step_row(1'b0, CMD_START,  16'hFFFF, 8'h00,    1'b1, 2'd0, NO_RES);
        dir_rows[16] = step_row(1'b0, CMD_TARGET, 16'h0000, BYTE_STX, 1'b0, 2'd0, NO_RES);
        dir_rows[17] = step_row(1'b0, CMD_TICK,   16'h0000, 8'h00,    1'b1, 2'd1,
                                mk_res(1'b0, 8'h00, 1'b1, 1'b0, 1'b1));
        dir_rows[18] = step_row(1'b0, CMD_START,  16'h0001, 8'h00,    1'b1, 2'd0, NO_RES);
        dir_rows[19] = step_row(1'b0, CMD_TARGET, 16'h0000, BYTE_STX, 1'b0, 2'd0, NO_RES);
        dir_rows[20] = step_row(1'b0, CMD_TARGET, 16'h0000, BYTE_ACK, 1'b1, 2'd0, NO_RES);
        dir_rows[21] = step_row(1'b0, CMD_TICK,   16'h0000, 8'h00,    1'b1, 2'd1,
                                mk_res(1'b1, BYTE_NAK, 1'b1, 1'b0, 1'b1));
        dir_rows[22] = step_row(1'b0, CMD_START,  16'h0000, 8'h00,    1'b1, 2'd0, NO_RES);
        dir_rows[23] = step_row(1'b0, CMD_TARGET, 16'h0000, BYTE_STX, 1'b0, 2'd0, NO_RES);
        dir_rows[24] = step_row(1'b0, CMD_TARGET, 16'h0000, BYTE_ACK, 1'b1, 2'd0, NO_RES);
        dir_rows[25] = step_row(1'b0, CMD_TICK,   16'h0000, 8'h00,    1'b1, 2'd1,
                                mk_res(1'b1, BYTE_NAK, 1'b1, 1'b0, 1'b1));

        send_idle_pct = 6;
        recv_idle_pct = 68;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].zero_first)
                write_timeouts('0, '0, '0);
            send_word(dir_rows[i].c, dir_rows[i].sz, dir_rows[i].b, dir_rows[i].typed,
                      dir_rows[i].n_typed, dir_rows[i].r);
        end

        // small limits, then limits that never expire, then small limits without idling
        for (p = 0; p < 3; p++)
        begin
            if (p == 1)
            begin
                send_idle_pct = 68;
                recv_idle_pct = 6;
                ts = TICK_MAX;
                tr = TICK_MAX;
                ti = TICK_MAX;
            end
            else
            begin
                if (p == 2)
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                ts = 20'($urandom_range(1, 8));
                tr = 20'($urandom_range(1, 8));
                ti = 20'($urandom_range(1, 8));
                flush_len = ((ts > tr) ? ((ts > ti) ? ts : ti) : ((tr > ti) ? tr : ti)) + 2;
            end
            write_timeouts(ts, tr, ti);
            phase_words = 0;
            while (phase_words < PHASE_WORDS)
                run_download(p != 1);
            if (p != 1)
                flush_ticks();
        end

        await_quiet();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/ubid_pkg.sv
hw/rtl/ubid_step.sv
hw/rtl/ubid_outbuf.sv
hw/rtl/uart_boot_image_download_host_core.sv
hw/rtl/ubid_checker.sv
test/uart_boot_image_download_host_core_tb.sv
